// File: design/ile_pkg.sv
// Package for the indexed list engine: field widths, defaults and codes.
package ile_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int WIDTH_DEFAULT = 32;

    localparam int ACTION_W = 3;
    localparam int POS_W    = 9;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ITEM_W   = 32;
    localparam int LEN_W    = 9;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND  = 3'd0,
        ACT_POP     = 3'd1,
        ACT_INSERT  = 3'd2,
        ACT_REMOVE  = 3'd3,
        ACT_READ    = 3'd4,
        ACT_WRITE   = 3'd5,
        ACT_REVERSE = 3'd6,
        ACT_CLEAR   = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_REM_ITEM,
        S_REM_SHIFT,
        S_INS_SHIFT,
        S_INS_PUT,
        S_REV_B,
        S_REV_C,
        S_REV_D
    } state_t;

endpackage

// File: design/indexed_list_engine.sv
// Indexed list engine: ordered word list in one synchronous memory with a sequencer.
//
//   channel   | handshake                 | fields
//   ----------+---------------------------+------------------------
//   request   | start, busy (accept when  | action, position, value
//             | start & !busy)            |
//   result    | done (one-cycle strobe)   | status, item, length
//
// Append, write, clear, rejected requests and reverse of fewer than two entries finish
// straight from idle; read and pop go through one memory read. Remove, insert and reverse
// shift or swap entries one at a time: the memory has one read and one write port
// and moves one entry per cycle. Reset clears the count and the sequencer state; entry
// contents stay undefined until written. Results cannot be stalled; done is registered
// and pulses after the last state of each transaction.
module indexed_list_engine #(
    parameter int DEPTH = ile_pkg::DEPTH_DEFAULT,
    parameter int WIDTH = ile_pkg::WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ile_pkg::ACTION_W-1:0]        action,
    input  logic signed [ile_pkg::POS_W-1:0]    position,
    input  logic [ile_pkg::VALUE_W-1:0]         value,
    output logic                                done,
    output logic [ile_pkg::STATUS_W-1:0]        status,
    output logic [ile_pkg::ITEM_W-1:0]          item,
    output logic [ile_pkg::LEN_W-1:0]           length
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 1;
    localparam int PW = ile_pkg::POS_W;
    localparam int RW = ((CW > PW) ? CW : PW) + 2;
    localparam int IW = ile_pkg::ITEM_W;
    localparam int LW = ile_pkg::LEN_W;

    logic [WIDTH-1:0] entries_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    ile_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    ptr_reg, ptr_next;
    logic [AW-1:0]    hi_reg, hi_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [WIDTH-1:0] val_reg, val_next;
    logic [WIDTH-1:0] hold_reg, hold_next;

    logic             done_reg, done_next;
    ile_pkg::status_t status_reg, status_next;
    logic [IW-1:0]    item_reg, item_next;
    logic [LW-1:0]    length_reg, length_next;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [WIDTH-1:0] wdata;
    logic [AW-1:0]    raddr;

    logic signed [RW-1:0] pos_s, cnt_s, idx_s;
    logic                 pos_ok;
    logic [AW-1:0]        idx;
    logic                 is_full;
    logic                 rev_more;

    assign pos_s  = RW'(position);
    assign cnt_s  = signed'(RW'(count_reg));
    assign idx_s  = position[PW-1] ? (cnt_s + pos_s) : pos_s;
    assign pos_ok = !idx_s[RW-1] && (idx_s < cnt_s);
    assign idx    = idx_s[AW-1:0];

    assign is_full  = (count_reg == CW'(DEPTH));
    assign rev_more = (XW'(ptr_reg) + XW'(2)) < XW'(hi_reg);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entries_mem[waddr] <= wdata;
        end
        rdata_reg <= entries_mem[raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        hi_next     = hi_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        hold_next   = hold_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        item_next   = item_reg;
        length_next = length_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        raddr       = '0;

        case (state_reg)
            ile_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_next   = '0;
                    status_next = ile_pkg::ST_OK;
                    case (ile_pkg::action_t'(action))
                        ile_pkg::ACT_APPEND:
                        begin
                            done_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = ile_pkg::ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = AW'(count_reg);
                                wdata      = WIDTH'(value);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        ile_pkg::ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ile_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                raddr      = AW'(count_reg - 1'b1);
                                state_next = ile_pkg::S_READ;
                            end
                        end
                        ile_pkg::ACT_INSERT:
                        begin
                            if (!pos_ok)
                            begin
                                done_next   = 1'b1;
                                status_next = ile_pkg::ST_RANGE;
                            end
                            else if (is_full)
                            begin
                                done_next   = 1'b1;
                                status_next = ile_pkg::ST_FULL;
                            end
                            else
                            begin
                                val_next   = WIDTH'(value);
                                idx_next   = idx;
                                ptr_next   = count_reg;
                                raddr      = AW'(count_reg - 1'b1);
                                state_next = ile_pkg::S_INS_SHIFT;
                            end
                        end
                        ile_pkg::ACT_REMOVE:
                        begin
                            if (!pos_ok)
                            begin
                                done_next   = 1'b1;
                                status_next = ile_pkg::ST_RANGE;
                            end
                            else
                            begin
                                raddr      = idx;
                                ptr_next   = CW'(idx);
                                state_next = ile_pkg::S_REM_ITEM;
                            end
                        end
                        ile_pkg::ACT_READ:
                        begin
                            if (!pos_ok)
                            begin
                                done_next   = 1'b1;
                                status_next = ile_pkg::ST_RANGE;
                            end
                            else
                            begin
                                raddr      = idx;
                                state_next = ile_pkg::S_READ;
                            end
                        end
                        ile_pkg::ACT_WRITE:
                        begin
                            done_next = 1'b1;
                            if (!pos_ok)
                            begin
                                status_next = ile_pkg::ST_RANGE;
                            end
                            else
                            begin
                                we    = 1'b1;
                                waddr = idx;
                                wdata = WIDTH'(value);
                            end
                        end
                        ile_pkg::ACT_REVERSE:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                raddr      = '0;
                                ptr_next   = '0;
                                hi_next    = AW'(count_reg - 1'b1);
                                state_next = ile_pkg::S_REV_B;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        ile_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ile_pkg::S_READ:
            begin
                item_next   = IW'(rdata_reg);
                done_next   = 1'b1;
                state_next  = ile_pkg::S_IDLE;
            end
            ile_pkg::S_REM_ITEM:
            begin
                hold_next = rdata_reg;
                if ((XW'(ptr_reg) + XW'(1)) >= XW'(count_reg))
                begin
                    count_next = count_reg - 1'b1;
                    item_next  = IW'(rdata_reg);
                    done_next  = 1'b1;
                    state_next = ile_pkg::S_IDLE;
                end
                else
                begin
                    raddr      = AW'(ptr_reg + 1'b1);
                    state_next = ile_pkg::S_REM_SHIFT;
                end
            end
            ile_pkg::S_REM_SHIFT:
            begin
                we    = 1'b1;
                waddr = AW'(ptr_reg);
                wdata = rdata_reg;
                if ((XW'(ptr_reg) + XW'(2)) < XW'(count_reg))
                begin
                    raddr    = AW'(ptr_reg + CW'(2));
                    ptr_next = ptr_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    item_next  = IW'(hold_reg);
                    done_next  = 1'b1;
                    state_next = ile_pkg::S_IDLE;
                end
            end
            ile_pkg::S_INS_SHIFT:
            begin
                we    = 1'b1;
                waddr = AW'(ptr_reg);
                wdata = rdata_reg;
                if (XW'(ptr_reg) > (XW'(idx_reg) + XW'(1)))
                begin
                    raddr    = AW'(ptr_reg - CW'(2));
                    ptr_next = ptr_reg - 1'b1;
                end
                else
                begin
                    state_next = ile_pkg::S_INS_PUT;
                end
            end
            ile_pkg::S_INS_PUT:
            begin
                we         = 1'b1;
                waddr      = idx_reg;
                wdata      = val_reg;
                count_next = count_reg + 1'b1;
                done_next  = 1'b1;
                state_next = ile_pkg::S_IDLE;
            end
            ile_pkg::S_REV_B:
            begin
                hold_next  = rdata_reg;
                raddr      = hi_reg;
                state_next = ile_pkg::S_REV_C;
            end
            ile_pkg::S_REV_C:
            begin
                we    = 1'b1;
                waddr = AW'(ptr_reg);
                wdata = rdata_reg;
                if (rev_more)
                begin
                    raddr = AW'(ptr_reg + 1'b1);
                end
                state_next = ile_pkg::S_REV_D;
            end
            ile_pkg::S_REV_D:
            begin
                we    = 1'b1;
                waddr = hi_reg;
                wdata = hold_reg;
                if (rev_more)
                begin
                    hold_next  = rdata_reg;
                    raddr      = hi_reg - 1'b1;
                    ptr_next   = ptr_reg + 1'b1;
                    hi_next    = hi_reg - 1'b1;
                    state_next = ile_pkg::S_REV_C;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ile_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ile_pkg::S_IDLE;
            end
        endcase

        if (done_next)
        begin
            length_next = LW'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ile_pkg::S_IDLE;
            count_reg <= '0;
            ptr_reg   <= '0;
            hi_reg    <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            hi_reg    <= hi_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        hold_reg   <= hold_next;
        status_reg <= status_next;
        item_reg   <= item_next;
        length_reg <= length_next;
    end

    assign busy   = (state_reg != ile_pkg::S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign item   = item_reg;
    assign length = length_reg;

endmodule
